// ===== design/pkrhr_pkg.sv =====
// Shared item types and codes for the per-key recent hash ring.
package pkrhr_pkg;

   // Request codes
   localparam logic [1:0] REQ_BACK = 2'd0;
   localparam logic [1:0] REQ_FWD  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;
   localparam logic [1:0] REQ_NONE = 2'd3;

   // Result status codes
   localparam logic [2:0] STAT_SKIP    = 3'd0;
   localparam logic [2:0] STAT_UNKNOWN = 3'd1;
   localparam logic [2:0] STAT_NEW     = 3'd2;
   localparam logic [2:0] STAT_INC     = 3'd3;
   localparam logic [2:0] STAT_SAT     = 3'd4;
   localparam logic [2:0] STAT_DROP    = 3'd5;
   localparam logic [2:0] STAT_READ    = 3'd6;

   // Control register indexes
   localparam logic CSR_SKIP_A = 1'b0;
   localparam logic CSR_SKIP_B = 1'b1;

   // Fixed field widths
   localparam int WALLET_ID_W = 10;
   localparam int SKIP_W      = 11;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [WALLET_ID_W-1:0] wallet_id;
      logic                   wallet_known;
      logic [63:0]            pool_hash;
   } pkrhr_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        entry_valid;
      logic [63:0] entry_hash;
      logic [7:0]  entry_count;
      logic        last;
   } pkrhr_rsp_type;

endpackage

// ===== design/per_key_recent_hash_ring.sv =====
// Top level of the per-key recent hash ring: sequencer and list state memories.
//
// Usage: an item is taken on req_data at a clock edge where start is high and
// busy is low. Each item gives one or more results on rsp_data, each shown for
// exactly one cycle with rsp_valid high; rsp_data.last marks the final one.
// The receiver cannot hold results off. Control registers (skipped wallet ids)
// are written through csr_we / csr_index / csr_wdata; the user must write them
// only while no item is in flight, as the block itself does not enforce this.
// Timing: the wallet index is formed in the cycle after acceptance; skipped,
// unknown and undefined requests then finish. Loads read the list state
// memory, then the entry memory, then write the entry memory and, for a new
// entry, the list state. A read of a list streams its entries, one entry per
// cycle from the entry memory's read port. The first result appears in the
// cycle after the cycle that decides it; a new item may be taken in the cycle
// that decides the last result of the previous one. Reset: a clearing pass
// writes empty list state to all WALLETS wallets, one wallet per cycle; busy stays high throughout.
module per_key_recent_hash_ring
   import pkrhr_pkg::*;
#(
   parameter int WALLETS    = 1024,
   parameter int LIST_DEPTH = 8,
   parameter int COUNT_MAX  = 255,
   parameter int HASH_BITS  = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pkrhr_req_type       req_data,
   output logic                rsp_valid,
   output pkrhr_rsp_type       rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [SKIP_W-1:0]   csr_wdata
);

   localparam int W_BITS  = $clog2(WALLETS);
   localparam int PTR_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int OCC_W   = $clog2(LIST_DEPTH + 1);
   localparam int OFF_W   = OCC_W + 1;
   localparam int CNT_W   = $clog2(COUNT_MAX + 1);
   localparam int SLOTS   = WALLETS * LIST_DEPTH;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int META_W  = PTR_W + OCC_W;
   localparam int ENT_W   = HASH_BITS + CNT_W;
   localparam int RSHIFT  = 20;
   localparam int RECIP   = (1 << RSHIFT) / WALLETS;
   localparam int PROD_W  = WALLET_ID_W + RSHIFT;
   localparam int QW_W    = WALLET_ID_W + 17;

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_IDX   = 3'd2;
   localparam logic [2:0] S_META  = 3'd3;
   localparam logic [2:0] S_ENTRY = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;

   // Wrap an offset from the list head into a slot position
   function automatic logic [PTR_W-1:0] wrap_pos(input logic [OFF_W-1:0] sum);
      logic [OFF_W-1:0] red;
      red = (sum >= OFF_W'(LIST_DEPTH)) ? sum - OFF_W'(LIST_DEPTH) : sum;
      return PTR_W'(red);
   endfunction

   logic [2:0]              state_ff, state_in;
   logic [SKIP_W-1:0]       skip_a_ff, skip_b_ff;
   logic [W_BITS-1:0]       clr_ff, clr_in;
   pkrhr_req_type           req_ff;
   logic [WALLET_ID_W-1:0]  quot_ff;
   logic [W_BITS-1:0]       wal_ff;
   logic [PTR_W-1:0]        head_ff;
   logic [OCC_W-1:0]        occ_ff;
   logic [OCC_W-1:0]        pos_ff, pos_in;
   logic                    rsp_valid_ff;
   pkrhr_rsp_type           rsp_data_ff;

   logic                    accept;
   logic                    finish;
   logic                    emit;
   pkrhr_rsp_type           rsp_in;
   logic [PROD_W-1:0]       prod;
   logic [QW_W-1:0]         quot_w;
   logic [WALLET_ID_W-1:0]  rem_raw;
   logic [WALLET_ID_W-1:0]  rem_fix;
   logic [W_BITS-1:0]       wal_idx;

   logic                    meta_we;
   logic [W_BITS-1:0]       meta_waddr;
   logic [META_W-1:0]       meta_wdata;
   logic [META_W-1:0]       meta_rdata;
   logic [W_BITS-1:0]       meta_raddr;
   logic [PTR_W-1:0]        head_rd;
   logic [OCC_W-1:0]        occ_rd;

   logic                    ent_we;
   logic [SLOT_W-1:0]       ent_waddr;
   logic [ENT_W-1:0]        ent_wdata;
   logic [SLOT_W-1:0]       ent_raddr;
   logic [ENT_W-1:0]        ent_rdata;
   logic [HASH_BITS-1:0]    hash_rd;
   logic [CNT_W-1:0]        cnt_rd;

   logic [SLOT_W-1:0]       slot_base;
   logic [HASH_BITS-1:0]    hash_new;
   logic                    is_load;
   logic                    is_skip;
   logic                    hit;
   logic [PTR_W-1:0]        head_dec;
   logic [PTR_W-1:0]        head_inc;
   logic [OCC_W-1:0]        pos_first;
   logic [OCC_W-1:0]        pos_next;

   assign accept    = start && !busy;
   assign busy      = !((state_ff == S_IDLE) || finish);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Wallet index: wallet_id modulo WALLETS by reciprocal and one correction
   assign prod    = PROD_W'(req_data.wallet_id) * PROD_W'(RECIP);
   assign quot_w  = QW_W'(quot_ff) * QW_W'(WALLETS);
   assign rem_raw = WALLET_ID_W'(QW_W'(req_ff.wallet_id) - quot_w);
   assign rem_fix = (QW_W'(rem_raw) >= QW_W'(WALLETS))
                    ? WALLET_ID_W'(QW_W'(rem_raw) - QW_W'(WALLETS)) : rem_raw;
   assign wal_idx = W_BITS'(rem_fix);

   // Unpack memory words
   assign head_rd = meta_rdata[META_W-1 -: PTR_W];
   assign occ_rd  = meta_rdata[OCC_W-1:0];
   assign hash_rd = ent_rdata[ENT_W-1 -: HASH_BITS];
   assign cnt_rd  = ent_rdata[CNT_W-1:0];

   assign slot_base = SLOT_W'(wal_ff) * SLOT_W'(LIST_DEPTH);
   assign hash_new  = req_ff.pool_hash[HASH_BITS-1:0];
   assign is_load   = (req_ff.req_type == REQ_BACK) || (req_ff.req_type == REQ_FWD);
   assign is_skip   = ((SKIP_W'(req_ff.wallet_id) == skip_a_ff)
                       || (SKIP_W'(req_ff.wallet_id) == skip_b_ff));
   assign hit       = (occ_ff != '0) && (hash_rd == hash_new);
   assign head_dec  = (head_ff == '0) ? PTR_W'(LIST_DEPTH - 1) : head_ff - 1'b1;
   assign head_inc  = (OFF_W'(head_ff) + 1'b1 >= OFF_W'(LIST_DEPTH))
                      ? '0 : head_ff + 1'b1;
   assign pos_first = (req_ff.req_type == REQ_FWD) ? occ_rd - 1'b1 : '0;
   assign pos_next  = pos_ff + 1'b1;

   // Sequence one item through index, list state and entry steps
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      pos_in     = pos_ff;
      finish     = 1'b0;
      emit       = 1'b0;
      rsp_in     = '0;
      rsp_in.last = 1'b1;
      meta_raddr = wal_idx;
      meta_we    = 1'b0;
      meta_waddr = wal_ff;
      meta_wdata = '0;
      ent_raddr  = slot_base + SLOT_W'(wrap_pos(OFF_W'(head_ff) + OFF_W'(pos_next)));
      ent_we     = 1'b0;
      ent_waddr  = slot_base + SLOT_W'(head_ff);
      ent_wdata  = {hash_new, CNT_W'(1)};

      case (state_ff)
         S_CLEAR: begin
            // Empty every list after reset
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == W_BITS'(WALLETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_IDX;
            end
         end
         S_IDX: begin
            // Finish items that never touch the lists
            if (req_ff.req_type == REQ_NONE || (is_load && is_skip)) begin
               emit = 1'b1;
               rsp_in.status = STAT_SKIP;
            end else if (is_load && !req_ff.wallet_known) begin
               emit = 1'b1;
               rsp_in.status = STAT_UNKNOWN;
            end else begin
               state_in = S_META;
            end
         end
         S_META: begin
            ent_raddr = slot_base + SLOT_W'(wrap_pos(OFF_W'(head_rd) + OFF_W'(pos_first)));
            pos_in    = '0;
            if (req_ff.req_type == REQ_READ && occ_rd == '0) begin
               emit = 1'b1;
               rsp_in.status = STAT_READ;
            end else if (req_ff.req_type == REQ_READ) begin
               state_in = S_READ;
            end else begin
               state_in = S_ENTRY;
            end
         end
         S_ENTRY: begin
            emit = 1'b1;
            rsp_in.entry_valid = 1'b1;
            if (hit) begin
               // Bump the matching end entry, or report it saturated
               ent_waddr = slot_base + SLOT_W'(wrap_pos(OFF_W'(head_ff) + OFF_W'(
                           (req_ff.req_type == REQ_FWD) ? occ_ff - 1'b1 : '0)));
               rsp_in.entry_hash = 64'(hash_rd);
               if (cnt_rd < CNT_W'(COUNT_MAX)) begin
                  ent_we    = 1'b1;
                  ent_wdata = {hash_rd, cnt_rd + 1'b1};
                  rsp_in.status = STAT_INC;
                  rsp_in.entry_count = 8'(cnt_rd + 1'b1);
               end else begin
                  rsp_in.status = STAT_SAT;
                  rsp_in.entry_count = 8'(cnt_rd);
               end
            end else if (req_ff.req_type == REQ_BACK && occ_ff == OCC_W'(LIST_DEPTH)) begin
               // Drop a new hash at the front of a full list
               rsp_in.entry_valid = 1'b0;
               rsp_in.status = STAT_DROP;
            end else begin
               // Push a new entry at the requested end
               ent_we  = 1'b1;
               meta_we = 1'b1;
               rsp_in.status = STAT_NEW;
               rsp_in.entry_hash = 64'(hash_new);
               rsp_in.entry_count = 8'(CNT_W'(1));
               if (req_ff.req_type == REQ_BACK) begin
                  ent_waddr  = slot_base + SLOT_W'(head_dec);
                  meta_wdata = {head_dec, occ_ff + 1'b1};
               end else begin
                  ent_waddr  = slot_base + SLOT_W'(wrap_pos(OFF_W'(head_ff) + OFF_W'(occ_ff)));
                  if (occ_ff == OCC_W'(LIST_DEPTH)) begin
                     meta_wdata = {head_inc, occ_ff};
                  end else begin
                     meta_wdata = {head_ff, occ_ff + 1'b1};
                  end
               end
            end
         end
         S_READ: begin
            // Stream one entry a cycle, front to back
            emit = 1'b1;
            rsp_in.status      = STAT_READ;
            rsp_in.entry_valid = 1'b1;
            rsp_in.entry_hash  = 64'(hash_rd);
            rsp_in.entry_count = 8'(cnt_rd);
            rsp_in.last        = (pos_next == occ_ff);
            pos_in = pos_next;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Close the item and take the next one if offered
      if (emit && rsp_in.last) begin
         finish = 1'b1;
         state_in = start ? S_IDX : S_IDLE;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         skip_a_ff    <= SKIP_W'(1024);
         skip_b_ff    <= SKIP_W'(1024);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= emit;
         if (csr_we && csr_index == CSR_SKIP_A) begin
            skip_a_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_SKIP_B) begin
            skip_b_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
      pos_ff      <= pos_in;
      if (accept) begin
         req_ff  <= req_data;
         quot_ff <= prod[PROD_W-1 -: WALLET_ID_W];
      end
      if (state_ff == S_IDX) begin
         wal_ff <= wal_idx;
      end
      if (state_ff == S_META) begin
         head_ff <= head_rd;
         occ_ff  <= occ_rd;
      end
   end

   // Per-wallet head and occupancy
   pkrhr_ram #(
      .WIDTH (META_W),
      .DEPTH (WALLETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   // Per-slot hash and count
   pkrhr_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

endmodule

// ===== design/pkrhr_ram.sv =====
// Simple dual-port synchronous memory with a registered read.
module pkrhr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
